[rtl/core/sjf_pkg.sv]
package sjf_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int DATA_W       = 16;
    localparam int TIME_W       = 21;
    localparam int JOB_INDEX_W  = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE
    } sjf_state_t;

endpackage

[rtl/core/sjf_nonpreemptive_scheduler_core.sv]
// non-preemptive shortest-job-first scheduler
// input channel: a job transaction is taken on a rising edge with start high and
// busy low; arrival_time and burst_time go into the next free slot in load order.
// up to min(MAX_JOBS, 16) jobs are kept, later ones are dropped.
// a transaction with last_job set (stored or dropped) starts the run and raises busy.
// each pick reads every stored job once through a single read port and one compare
// unit: a scan state steps through the stored jobs, a flush state drains the read
// register and a decide state makes the pick. when no pending job has arrived, the
// clock jumps to the earliest pending arrival and the scan is repeated.
// result channel: each schedule entry is shown for exactly one cycle with
// result_valid high, in the cycle after its pick; last_entry marks the final one.
// the receiver cannot stall; every strobed entry counts as delivered.
// busy drops together with the final strobe, and the batch state is already
// cleared then, so the next load may start in that same cycle.
// reset empties the batch: job count, clock and finished flags go to zero.
module sjf_nonpreemptive_scheduler_core #(
    parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sjf_pkg::DATA_W-1:0]      arrival_time,
    input  logic [sjf_pkg::DATA_W-1:0]      burst_time,
    input  logic                           last_job,
    output logic                           result_valid,
    output logic [sjf_pkg::JOB_INDEX_W-1:0] job_index,
    output logic [sjf_pkg::TIME_W-1:0]      start_time,
    output logic [sjf_pkg::TIME_W-1:0]      finish_time,
    output logic [sjf_pkg::TIME_W-1:0]      turnaround,
    output logic [sjf_pkg::TIME_W-1:0]      waiting,
    output logic                           last_entry
);
    import sjf_pkg::*;

    localparam int CAP   = (MAX_JOBS < RESULT_LIMIT) ? MAX_JOBS : RESULT_LIMIT;
    localparam int IDX_W = $clog2(CAP);
    localparam int CNT_W = $clog2(CAP + 1);

    sjf_state_t state_reg, state_next;

    logic [DATA_W-1:0] arrival_mem [CAP];
    logic [DATA_W-1:0] burst_mem   [CAP];

    logic [CAP-1:0]    done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  produced_reg;
    logic [TIME_W-1:0] time_reg;
    logic [IDX_W-1:0]  scan_idx_reg;

    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [DATA_W-1:0] rd_arr_reg;
    logic [DATA_W-1:0] rd_burst_reg;

    logic              best_valid_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DATA_W-1:0] best_arr_reg;
    logic [DATA_W-1:0] best_burst_reg;
    logic [DATA_W-1:0] min_pend_reg;

    logic              strobe_reg;

    logic              accept;
    logic              store_ok;
    logic              scan_last;
    logic              scan_begin;
    logic              emit;
    logic              run_end;
    logic              pending;
    logic              eligible;
    logic              better;
    logic [TIME_W-1:0] finish_calc;

    assign accept   = start && (state_reg == ST_IDLE);
    assign store_ok = count_reg < CNT_W'(CAP);
    assign scan_last = scan_idx_reg == IDX_W'(count_reg - CNT_W'(1));

    // compare unit on the job coming out of the read register
    assign pending  = rd_valid_reg && !done_reg[rd_idx_reg];
    assign eligible = pending && (TIME_W'(rd_arr_reg) <= time_reg);
    assign better   = !best_valid_reg || (rd_burst_reg < best_burst_reg) ||
                      ((rd_burst_reg == best_burst_reg) && (rd_arr_reg < best_arr_reg));

    assign finish_calc = time_reg + TIME_W'(best_burst_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_job)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
                state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (best_valid_reg && (produced_reg + CNT_W'(1) == count_reg))
                    state_next = ST_IDLE;
                else
                    state_next = ST_SCAN;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        busy       = 1'b1;
        scan_begin = 1'b0;
        emit       = 1'b0;
        run_end    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                scan_begin = accept && last_job;
            end
            ST_SCAN, ST_FLUSH:
                ;
            ST_DECIDE:
            begin
                emit       = best_valid_reg;
                run_end    = best_valid_reg && (produced_reg + CNT_W'(1) == count_reg);
                scan_begin = !run_end;
            end
            default:
                busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= '0;
            count_reg      <= '0;
            produced_reg   <= '0;
            time_reg       <= '0;
            scan_idx_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_SCAN);
            strobe_reg   <= emit;

            if (accept && store_ok)
                count_reg <= count_reg + CNT_W'(1);

            if (state_reg == ST_SCAN)
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (scan_begin)
                scan_idx_reg <= '0;

            if (eligible && better)
                best_valid_reg <= 1'b1;
            if (scan_begin)
                best_valid_reg <= 1'b0;

            // no arrived job: jump to the earliest pending arrival and rescan
            if ((state_reg == ST_DECIDE) && !best_valid_reg)
                time_reg <= TIME_W'(min_pend_reg);

            if (emit)
            begin
                time_reg               <= finish_calc;
                done_reg[best_idx_reg] <= 1'b1;
                produced_reg           <= produced_reg + CNT_W'(1);
            end

            if (run_end)
            begin
                done_reg     <= '0;
                count_reg    <= '0;
                produced_reg <= '0;
                time_reg     <= '0;
            end
        end
    end

    // job store and its registered read port
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            arrival_mem[IDX_W'(count_reg)] <= arrival_time;
            burst_mem[IDX_W'(count_reg)]   <= burst_time;
        end
        rd_arr_reg   <= arrival_mem[scan_idx_reg];
        rd_burst_reg <= burst_mem[scan_idx_reg];
        rd_idx_reg   <= scan_idx_reg;
    end

    // running best and earliest pending arrival
    always_ff @(posedge clk)
    begin
        if (eligible && better)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_arr_reg   <= rd_arr_reg;
            best_burst_reg <= rd_burst_reg;
        end
        if (pending && (rd_arr_reg < min_pend_reg))
            min_pend_reg <= rd_arr_reg;
        if (scan_begin)
            min_pend_reg <= '1;
    end

    // schedule entry register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            job_index   <= JOB_INDEX_W'(best_idx_reg);
            start_time  <= time_reg;
            finish_time <= finish_calc;
            turnaround  <= finish_calc - TIME_W'(best_arr_reg);
            waiting     <= time_reg - TIME_W'(best_arr_reg);
            last_entry  <= run_end;
        end
    end

    assign result_valid = strobe_reg;

`ifndef NO_ASSERTIONS
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a run in progress");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_entry) |-> !busy)
        else $error("final entry shown while still busy");

    a_produced_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (produced_reg < count_reg))
        else $error("more entries produced than jobs stored");

    a_batch_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_entry) |-> (count_reg == '0))
        else $error("batch state not cleared after the final entry");
`endif

endmodule
